// ===== hw/rtl/task_scheduler_select_unit_assert.svh =====
// Assertion macros for the scheduler RTL.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef TASK_SCHEDULER_SELECT_UNIT_ASSERT_SVH
`define TASK_SCHEDULER_SELECT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define TSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tss_pkg.sv =====
package tss_pkg;

    // Default size of the task table.
    localparam int TSS_MAX_TASKS = 16;

    // Fixed field widths.
    localparam int IDX_W  = 4;
    localparam int PRIO_W = 8;
    localparam int CNT_W  = 5;

    // Item operation codes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCHED = 1'b1
    } t_op;

    // Scheduling modes.
    typedef enum logic {
        MODE_RR   = 1'b0,
        MODE_PRIO = 1'b1
    } t_mode;

    // Configuration register indexes.
    typedef enum logic {
        CFG_MODE  = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_reg;

    // One task table entry.
    typedef struct packed {
        logic              ready;
        logic [PRIO_W-1:0] prio;
        logic              idle;
    } t_entry;

    // One input request.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        t_entry           entry;
    } t_item;

    // One result.
    typedef struct packed {
        logic [IDX_W-1:0] sel_index;
        logic             sel_valid;
    } t_result;

endpackage

// ===== hw/rtl/tss_ram.sv =====
module tss_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16
    )
    (
        input  logic                     i_clk,
        input  logic                     i_wr_en,
        input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
        input  logic [WIDTH-1:0]         i_wr_data,
        input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
        output logic [WIDTH-1:0]         o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// ===== hw/rtl/tss_table.sv =====
module tss_table
    import tss_pkg::*;
    #(
        parameter int MAX_TASKS = TSS_MAX_TASKS
    )
    (
        input  logic                         i_clk,
        input  logic                         i_rst_n,
        input  logic                         i_wr_en,
        input  logic [$clog2(MAX_TASKS)-1:0] i_wr_addr,
        input  t_entry                       i_wr_entry,
        input  logic [$clog2(MAX_TASKS)-1:0] i_rd_addr,
        output t_entry                       o_rd_entry
    );

    localparam int ENTRY_W = $bits(t_entry);

    logic [MAX_TASKS-1:0] r_valid;
    logic                 r_rd_valid;
    logic [ENTRY_W-1:0]   ram_q;

    // Entry storage.
    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_entry),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // Written marks; an entry never written reads as cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // The mark is read alongside the memory so both arrive together.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_rd_addr];
    end

    assign o_rd_entry = r_rd_valid ? t_entry'(ram_q) : '0;

endmodule

// ===== hw/rtl/tss_engine.sv =====
module tss_engine
    import tss_pkg::*;
    #(
        parameter int MAX_TASKS = TSS_MAX_TASKS
    )
    (
        input  logic                           i_clk,
        input  logic                           i_rst_n,
        input  logic                           i_start,
        input  t_item                          i_item,
        input  t_mode                          i_mode,
        input  logic [$clog2(MAX_TASKS+1)-1:0] i_count,
        output logic                           o_busy,
        output logic                           o_wr_en,
        output logic [$clog2(MAX_TASKS)-1:0]   o_wr_addr,
        output t_entry                         o_wr_entry,
        output logic [$clog2(MAX_TASKS)-1:0]   o_rd_addr,
        input  t_entry                         i_rd_entry,
        output logic                           o_done,
        output t_result                        o_result,
        input  logic                           i_taken
    );

    localparam int AW  = $clog2(MAX_TASKS);
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int LW  = CW + 1;
    localparam int IW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int IRW = IW + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WRAP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_pos, n_pos;
    logic [LW-1:0]     r_issue, n_issue;
    logic              r_rd_vld, n_rd_vld;
    logic [AW-1:0]     r_rd_pos, n_rd_pos;
    logic              r_idle_seen, n_idle_seen;
    logic [PRIO_W-1:0] r_best, n_best;
    logic [AW-1:0]     r_sel, n_sel;
    logic [AW-1:0]     r_running, n_running;
    t_result           r_result, n_result;

    logic [IW-1:0]     idx_wide;
    logic              wr_in_range;
    logic [LW-1:0]     limit;
    logic [CW-1:0]     pos_inc;
    logic [CW-1:0]     pos_next;
    logic              finish;
    logic [AW-1:0]     fin_sel;
    logic [IW-1:0]     fin_wide;

    // Write address; indexes past the table are dropped.
    assign idx_wide    = IW'(i_item.index);
    assign wr_in_range = ({1'b0, idx_wide} < IRW'(MAX_TASKS));
    assign o_wr_addr   = idx_wide[AW-1:0];
    assign o_wr_entry  = i_item.entry;

    // Round robin walks two passes, priority mode one.
    assign limit = (i_mode == MODE_RR) ? {i_count, 1'b0} : {1'b0, i_count};

    // Next scan position, wrapping at the task count.
    assign pos_inc  = r_pos + CW'(1);
    assign pos_next = (pos_inc == i_count) ? '0 : pos_inc;

    assign o_rd_addr = r_pos[AW-1:0];
    assign fin_wide  = IW'(fin_sel);

    // Sequencer and the shared compare unit.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_rd_pos    = r_rd_pos;
        n_idle_seen = r_idle_seen;
        n_best      = r_best;
        n_sel       = r_sel;
        n_running   = r_running;
        n_result    = r_result;
        o_wr_en     = 1'b0;
        finish      = 1'b0;
        fin_sel     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_item.op == OP_WRITE) begin
                        o_wr_en  = wr_in_range;
                        n_result = '{sel_index: '0, sel_valid: 1'b0};
                        n_state  = ST_DONE;
                    end else begin
                        n_issue     = '0;
                        n_idle_seen = 1'b0;
                        n_best      = '0;
                        n_sel       = '0;
                        if (i_mode == MODE_PRIO) begin
                            n_pos   = '0;
                            n_state = ST_SCAN;
                        end else begin
                            n_pos   = CW'(r_running) + CW'(1);
                            n_state = ST_WRAP;
                        end
                    end
                end
            end
            ST_WRAP: begin
                // Reduce the start position modulo the count, one subtraction a cycle.
                if (r_pos >= i_count) begin
                    n_pos = r_pos - i_count;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next table read.
                if (r_issue != limit) begin
                    n_rd_vld = 1'b1;
                    n_rd_pos = r_pos[AW-1:0];
                    n_pos    = pos_next;
                    n_issue  = r_issue + LW'(1);
                end
                // Judge the entry that came back this cycle.
                if (r_rd_vld) begin
                    if (i_mode == MODE_RR) begin
                        if (i_rd_entry.idle) begin
                            if (r_idle_seen) begin
                                finish  = 1'b1;
                                fin_sel = '0;
                            end else begin
                                n_idle_seen = 1'b1;
                            end
                        end else if (i_rd_entry.ready) begin
                            finish  = 1'b1;
                            fin_sel = r_rd_pos;
                        end
                    end else if (i_rd_entry.ready) begin
                        if (i_rd_entry.prio > r_best) begin
                            n_best = i_rd_entry.prio;
                            n_sel  = r_rd_pos;
                        end else if (i_rd_entry.prio == r_best && r_rd_pos == r_running) begin
                            n_sel = r_rd_pos;
                        end
                    end
                    // Last entry judged without a round-robin pick.
                    if (!finish && r_issue == limit) begin
                        finish  = 1'b1;
                        fin_sel = (i_mode == MODE_PRIO) ? n_sel : '0;
                    end
                end
                if (finish) begin
                    n_running = fin_sel;
                    n_result  = '{sel_index: fin_wide[IDX_W-1:0], sel_valid: 1'b1};
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_running <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_running <= n_running;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_issue     <= n_issue;
        r_rd_pos    <= n_rd_pos;
        r_idle_seen <= n_idle_seen;
        r_best      <= n_best;
        r_sel       <= n_sel;
        r_result    <= n_result;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_result = r_result;

endmodule

// ===== hw/rtl/task_scheduler_select_unit.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------------------
// request   | in        | i_in_valid / o_in_stall   | operation, entry index, ready, priority,
//           |           |                           | idle mark
// result    | out       | o_out_valid / i_out_stall | selected index, selected valid
// config    | in        | i_cfg_valid / o_cfg_ready | register index, write data
//
// A write request passes the sequencer's done state before the output register takes it.
// Round robin first reduces the start position modulo the task count n (0 to MAX_TASKS
// subtractions), then reads up to two passes of n entries; priority mode reads one pass.
// The rate is set by the one-entry-per-cycle read of the task table memory.
// Synchronous active-low reset clears the table and running task; mode resets to RR, count to 1.
// A stalled result waits in the output register while the next request is worked on.
`include "task_scheduler_select_unit_assert.svh"

module task_scheduler_select_unit
    import tss_pkg::*;
    #(
        parameter int MAX_TASKS = TSS_MAX_TASKS
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  logic              i_in_valid,
        output logic              o_in_stall,
        input  logic              i_operation,
        input  logic [IDX_W-1:0]  i_entry_index,
        input  logic              i_entry_ready,
        input  logic [PRIO_W-1:0] i_entry_priority,
        input  logic              i_entry_is_idle,
        output logic              o_out_valid,
        input  logic              i_out_stall,
        output logic [IDX_W-1:0]  o_selected_index,
        output logic              o_selected_valid,
        input  logic              i_cfg_valid,
        output logic              o_cfg_ready,
        input  logic              i_cfg_index,
        input  logic [CNT_W-1:0]  i_cfg_data
    );

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_mode         r_mode;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    t_result       r_out;

    t_item         item;
    logic          in_accept;
    logic          busy;
    logic          done;
    logic          taken;
    logic          out_free;
    t_result       result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_entry;
    logic [AW-1:0] rd_addr;
    t_entry        rd_entry;

    // Configuration writes are always taken; the count is stored clamped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RR;
            r_count <= CW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (t_cfg_reg'(i_cfg_index) == CFG_MODE) begin
                r_mode <= t_mode'(i_cfg_data[0]);
            end else if (i_cfg_data == '0) begin
                r_count <= CW'(1);
            end else if (32'(i_cfg_data) > MAX_TASKS) begin
                r_count <= CW'(MAX_TASKS);
            end else begin
                r_count <= CW'(i_cfg_data);
            end
        end
    end

    // Request intake.
    assign item = '{
        op:    t_op'(i_operation),
        index: i_entry_index,
        entry: '{ready: i_entry_ready, prio: i_entry_priority, idle: i_entry_is_idle}
    };
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Task table.
    tss_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    // Selection sequencer.
    tss_engine #(
        .MAX_TASKS (MAX_TASKS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_item     (item),
        .i_mode     (r_mode),
        .i_count    (r_count),
        .o_busy     (busy),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_entry (wr_entry),
        .o_rd_addr  (rd_addr),
        .i_rd_entry (rd_entry),
        .o_done     (done),
        .o_result   (result),
        .i_taken    (taken)
    );

    // Output register; it is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign taken    = done && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (taken) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (taken) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out.sel_index;
    assign o_selected_valid = r_out.sel_valid;

    // An accepted request always occupies the sequencer in the next cycle.
    `TSS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, o_in_stall)
    // A write acknowledgement carries index zero.
    `TSS_ASSERT_IMP(a_ack_zero, i_clk, i_rst_n, o_out_valid && !o_selected_valid, ~|o_selected_index)
    // A new result only appears after the sequencer was busy with it.
    `TSS_ASSERT_IMP(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

// ===== dv/task_scheduler_select_unit_test.sv =====
module task_scheduler_select_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT = 27;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 64;

    // Whether a directed row carries its expected result or takes it from the predictor.
    localparam bit GIVEN = 1'b1;
    localparam bit CALC  = 1'b0;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_item            item;
        bit               typed;
        logic [IDX_W-1:0] want_index;
        t_mode            mode;
        logic [CNT_W-1:0] count;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_operation;
    logic [IDX_W-1:0]  i_entry_index;
    logic              i_entry_ready;
    logic [PRIO_W-1:0] i_entry_priority;
    logic              i_entry_is_idle;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [IDX_W-1:0]  o_selected_index;
    logic              o_selected_valid;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [CNT_W-1:0]  i_cfg_data;

    // Predictor state: task table, running task and configuration.
    t_entry           task_tbl [TSS_MAX_TASKS];
    int               running_task;
    t_mode            sched_mode;
    logic [CNT_W-1:0] sched_count;

    t_result   pending_selections [$];
    t_plan_row plan_q [$];

    int  mismatches;
    int  writes_done;
    int  rr_decisions;
    int  prio_decisions;
    int  settings_used;
    bit  gaps_on;
    int  hold_requests;

    task_scheduler_select_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_entry_index    (i_entry_index),
        .i_entry_ready    (i_entry_ready),
        .i_entry_priority (i_entry_priority),
        .i_entry_is_idle  (i_entry_is_idle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_selected_index (o_selected_index),
        .o_selected_valid (o_selected_valid),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Count in use after clamping to the table size.
    function automatic int used_count(input logic [CNT_W-1:0] c);
        if (c < 1) return 1;
        if (c > TSS_MAX_TASKS) return TSS_MAX_TASKS;
        return int'(c);
    endfunction

    // Applies one request to the predicted table and returns the result it should produce.
    function automatic t_result next_selection(input t_item r);
        t_result res;
        int      n;
        int      pos;
        int      idle_seen;
        int      best;
        int      pick;
        bit      done;
        res = '0;
        if (r.op == OP_WRITE) begin
            task_tbl[r.index] = r.entry;
            writes_done++;
            return res;
        end
        n = used_count(sched_count);
        pick = 0;
        if (sched_mode == MODE_RR) begin
            // Scan onward from the running task, giving up on a second idle entry.
            pos = running_task;
            idle_seen = 0;
            done = 1'b0;
            for (int step = 0; step < 2 * n && !done; step++) begin
                pos = (pos + 1) % n;
                if (task_tbl[pos].idle) begin
                    idle_seen++;
                    if (idle_seen > 1) done = 1'b1;
                end else if (task_tbl[pos].ready) begin
                    pick = pos;
                    done = 1'b1;
                end
            end
            rr_decisions++;
        end else begin
            // Highest priority wins; a tie moves the choice only onto the running task.
            best = 0;
            for (int i = 0; i < n; i++) begin
                if (task_tbl[i].ready) begin
                    if (task_tbl[i].prio > best) begin
                        best = task_tbl[i].prio;
                        pick = i;
                    end else if (task_tbl[i].prio == best && i == running_task) begin
                        pick = i;
                    end
                end
            end
            prio_decisions++;
        end
        running_task = pick;
        res.sel_index = pick[IDX_W-1:0];
        res.sel_valid = 1'b1;
        return res;
    endfunction

    function automatic t_plan_row req_row(input t_op op, input int idx, input bit rdy,
                                          input int prio, input bit idle, input bit typed,
                                          input int want);
        t_plan_row row;
        row.kind = ROW_REQ;
        row.item.op = op;
        row.item.index = idx[IDX_W-1:0];
        row.item.entry.ready = rdy;
        row.item.entry.prio = prio[PRIO_W-1:0];
        row.item.entry.idle = idle;
        row.typed = typed;
        row.want_index = want[IDX_W-1:0];
        row.mode = MODE_RR;
        row.count = '0;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input t_mode m, input int c);
        t_plan_row row;
        row = req_row(OP_WRITE, 0, 1'b0, 0, 1'b0, CALC, 0);
        row.kind = ROW_CFG;
        row.mode = m;
        row.count = c[CNT_W-1:0];
        return row;
    endfunction

    // Random request: mostly entries in use, ready tasks, and priorities that often tie.
    function automatic t_item make_request(input logic [CNT_W-1:0] c);
        t_item r;
        int    n;
        n = used_count(c);
        r.op = ($urandom_range(99) < 40) ? OP_WRITE : OP_SCHED;
        if ($urandom_range(99) < 80) r.index = IDX_W'($urandom_range(n - 1));
        else r.index = IDX_W'($urandom_range(TSS_MAX_TASKS - 1));
        r.entry.ready = ($urandom_range(99) < 70);
        case ($urandom_range(3))
            0: r.entry.prio = PRIO_W'($urandom_range(2));
            1: r.entry.prio = PRIO_W'(255 - $urandom_range(1));
            default: r.entry.prio = PRIO_W'($urandom_range(255));
        endcase
        r.entry.idle = ($urandom_range(99) < 8);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return CNT_W'(1);
            2: return CNT_W'(TSS_MAX_TASKS);
            3: return CNT_W'($urandom_range(31, TSS_MAX_TASKS + 1));
            default: return CNT_W'($urandom_range(TSS_MAX_TASKS, 1));
        endcase
    endfunction

    // Offers one request, with a random gap first, and records its expected result.
    task automatic offer_request(input t_item r, input bit typed,
                                 input logic [IDX_W-1:0] want_index);
        t_result res;
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= r.op;
        i_entry_index    <= r.index;
        i_entry_ready    <= r.entry.ready;
        i_entry_priority <= r.entry.prio;
        i_entry_is_idle  <= r.entry.idle;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = next_selection(r);
        if (typed) begin
            res.sel_index = want_index;
            res.sel_valid = (r.op == OP_SCHED);
        end
        pending_selections.push_back(res);
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_selections.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both configuration registers back to back.
    task automatic program_scheduler(input t_mode m, input logic [CNT_W-1:0] c);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= CNT_W'(m);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sched_mode = m;
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= c;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sched_count = c;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stalls, quiet stretches, and a long hold when requested.
    initial begin
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!gaps_on) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_selections.size() == 0) begin
                $display("%0t: unexpected result index %0d valid %0b", $time,
                         o_selected_index, o_selected_valid);
                mismatches++;
            end else begin
                want = pending_selections.pop_front();
                if (o_selected_index !== want.sel_index) begin
                    $display("%0t: selected_index expected %0d, got %0d", $time,
                             want.sel_index, o_selected_index);
                    mismatches++;
                end
                if (o_selected_valid !== want.sel_valid) begin
                    $display("%0t: selected_valid expected %0b, got %0b", $time,
                             want.sel_valid, o_selected_valid);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_mode            m;
        logic [CNT_W-1:0] c;

        // Known input values and the reset state of the predictor.
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_operation      = OP_WRITE;
        i_entry_index    = '0;
        i_entry_ready    = 1'b0;
        i_entry_priority = '0;
        i_entry_is_idle  = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_MODE;
        i_cfg_data       = '0;
        for (int i = 0; i < TSS_MAX_TASKS; i++) task_tbl[i] = '0;
        running_task   = 0;
        sched_mode     = MODE_RR;
        sched_count    = CNT_W'(1);
        mismatches     = 0;
        writes_done    = 0;
        rr_decisions   = 0;
        prio_decisions = 0;
        settings_used  = 0;
        gaps_on        = 1'b1;
        hold_requests  = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, extremes, idle wrap, ties, count clamping.
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_WRITE, 15, 1, 255, 1, GIVEN, 0));
        plan_q.push_back(req_row(OP_WRITE, 0, 0, 0, 0, GIVEN, 0));
        plan_q.push_back(cfg_row(MODE_RR, 16));
        plan_q.push_back(req_row(OP_WRITE, 3, 1, 10, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_WRITE, 7, 1, 200, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_WRITE, 5, 0, 0, 1, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(cfg_row(MODE_PRIO, 16));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_WRITE, 15, 0, 0, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_WRITE, 3, 1, 200, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_WRITE, 7, 1, 201, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_WRITE, 7, 1, 200, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(cfg_row(MODE_RR, 4));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(cfg_row(MODE_PRIO, 0));
        plan_q.push_back(req_row(OP_WRITE, 0, 1, 0, 0, GIVEN, 0));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, GIVEN, 0));
        plan_q.push_back(cfg_row(MODE_RR, 31));
        plan_q.push_back(req_row(OP_SCHED, 0, 0, 0, 0, CALC, 0));
        plan_q.push_back(req_row(OP_WRITE, 0, 0, 255, 0, GIVEN, 0));

        foreach (plan_q[k]) begin
            if (plan_q[k].kind == ROW_CFG) begin
                drain_results();
                program_scheduler(plan_q[k].mode, plan_q[k].count);
            end else begin
                offer_request(plan_q[k].item, plan_q[k].typed, plan_q[k].want_index);
            end
        end

        // Random phases, each under its own setting; extremes come first.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin m = MODE_RR;   c = CNT_W'(TSS_MAX_TASKS); end
                1: begin m = MODE_PRIO; c = CNT_W'(TSS_MAX_TASKS); end
                2: begin m = MODE_RR;   c = CNT_W'(1);             end
                3: begin m = MODE_PRIO; c = CNT_W'(1);             end
                default: begin
                    m = t_mode'($urandom_range(1));
                    c = pick_count();
                end
            endcase
            drain_results();
            program_scheduler(m, c);
            gaps_on = (ph != 6);
            if (ph == 4) hold_requests++;
            repeat (PHASE_ITEMS) offer_request(make_request(c), CALC, '0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d table writes, %0d round-robin and %0d priority decisions",
                 writes_done, rr_decisions, prio_decisions);
        $display("under %0d scheduler settings, with random stalls and one long output hold.",
                 settings_used);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
